/* rtl/wcm_pkg.sv */
package wcm_pkg;

  localparam int MAX_WORDS    = 6;
  localparam int MAX_WORD_LEN = 8;
  localparam int MAX_TEXT_LEN = 65536;

  localparam int WORD_REGS = 6;
  localparam int WIN_DEPTH = MAX_WORDS * MAX_WORD_LEN;
  localparam int WORD_W    = 8 * MAX_WORD_LEN;
  localparam int LEN_W     = $clog2(MAX_WORD_LEN + 1);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int SPAN_W    = $clog2(WIN_DEPTH + 1);
  localparam int TPOS_W    = $clog2(MAX_TEXT_LEN);
  localparam int MS_W      = 16;
  localparam int POS_W     = (TPOS_W > MS_W) ? TPOS_W : MS_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_LEN_W = 4;
  localparam int CFG_CNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_CNT = CFG_IDX_W'(7);

  typedef logic [7:0]        byte_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
  } wcm_cfg_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (32'(v) > MAX_WORD_LEN) begin
      r = LEN_W'(MAX_WORD_LEN);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] eff_cnt(input logic [CFG_CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_WORDS) begin
      r = CNT_W'(MAX_WORDS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/wcm_cell.sv */
module wcm_cell
  import wcm_pkg::*;
(
  input  logic  clk,
  input  logic  shift,
  input  logic  clear,
  input  byte_t din,
  output byte_t q
);

  byte_t q_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= clear ? '0 : din;
    end
  end

  assign q = q_r;

endmodule

/* rtl/wcm_match.sv */
module wcm_match
  import wcm_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  byte_t    win [WIN_DEPTH],
  input  word_t    words [WORD_REGS],
  input  wcm_cfg_t cfg,
  output logic     hit
);

  word_t chunk [MAX_WORDS];
  word_t mask;
  logic [MAX_WORDS-1:0] eq_nxt [MAX_WORDS];
  logic [MAX_WORDS-1:0] eq_r   [MAX_WORDS];
  logic [MAX_WORDS-1:0] weq_nxt [MAX_WORDS];
  logic [MAX_WORDS-1:0] weq_r   [MAX_WORDS];

  // chunk c, byte j sits at age c*len + len-1-j
  always_comb begin
    for (int j = 0; j < MAX_WORD_LEN; j++) begin
      mask[j*8 +: 8] = (LEN_W'(j) < cfg.len) ? 8'hFF : 8'h00;
    end
    for (int c = 0; c < MAX_WORDS; c++) begin
      for (int j = 0; j < MAX_WORD_LEN; j++) begin
        chunk[c][j*8 +: 8] = 8'h00;
        for (int l = j + 1; l <= MAX_WORD_LEN; l++) begin
          if (cfg.len == LEN_W'(l)) begin
            chunk[c][j*8 +: 8] = win[c*l + l - 1 - j];
          end
        end
      end
    end
    for (int c = 0; c < MAX_WORDS; c++) begin
      for (int k = 0; k < MAX_WORDS; k++) begin
        eq_nxt[c][k]  = (chunk[c] == (words[k] & mask));
        weq_nxt[c][k] = ((words[c] & mask) == (words[k] & mask));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eq_r  <= eq_nxt;
      weq_r <= weq_nxt;
    end
  end

  // multiset equality: per active word, chunk hits equal word duplicates
  always_comb begin
    logic [CNT_W-1:0] n_chunk;
    logic [CNT_W-1:0] n_word;
    hit = 1'b1;
    for (int k = 0; k < MAX_WORDS; k++) begin
      n_chunk = '0;
      n_word  = '0;
      for (int c = 0; c < MAX_WORDS; c++) begin
        if (CNT_W'(c) < cfg.cnt) begin
          n_chunk = n_chunk + CNT_W'(eq_r[c][k]);
          n_word  = n_word + CNT_W'(weq_r[c][k]);
        end
      end
      if ((CNT_W'(k) < cfg.cnt) && (n_chunk != n_word)) begin
        hit = 1'b0;
      end
    end
  end

endmodule

/* rtl/word_concatenation_matcher_top.sv */
// Word concatenation matcher.
// Input channel (in_valid/in_ready): one text byte per transfer, with
// in_start_of_text marking position zero of a new text. Result channel
// (out_valid/out_ready): out_match_start, the start position of a span of
// the text that is a concatenation of all active words in any order, one
// result at most per input byte, reported for the span ending at that byte.
// Config channel (cfg_valid/cfg_ready, always ready): index 0..5 word
// registers, 6 word length, 7 word count; write only while idle.
// Throughput: one byte per cycle unless a stalled result blocks input. A
// result reaches out_valid through the chunk compare register, then the
// per-word counts into the output register.
// A 48-byte chain of cells holds the window; six chunk compares run in
// parallel against six words, then per-word counts are compared.
// Reset: config returns to its defaults, counters clear; window bytes are
// not reset, the fill count keeps stale bytes out of the compare; no
// clearing pass. On a receiver stall the result is held in the output
// register; input is refused only when a further result is ready behind it.
module word_concatenation_matcher_top
  import wcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_text_char,
  input  logic                 in_start_of_text,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MS_W-1:0]      out_match_start,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  localparam logic [TPOS_W-1:0] POS_LAST = TPOS_W'(MAX_TEXT_LEN - 1);

  word_t            words_r [WORD_REGS];
  logic [LEN_W-1:0] len_r;
  logic [CNT_W-1:0] cnt_r;
  wcm_cfg_t         cfg;

  byte_t win [WIN_DEPTH];

  logic [TPOS_W-1:0] text_position_r;
  logic [SPAN_W-1:0] bytes_seen_r;
  logic              past_end_r;

  logic              s1_v_r, s2_v_r, out_valid_r;
  logic [MS_W-1:0]   s1_pos_r, s2_pos_r, out_pos_r;

  logic                     in_fire, advance, hit;
  logic [LEN_W+CNT_W-1:0]   span_prod;
  logic [SPAN_W-1:0]        span, bytes_seen_nxt;
  logic [TPOS_W-1:0]        idx;
  logic                     past_eff, elig;
  logic [POS_W-1:0]         pos;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORD_REGS; i++) begin
        words_r[i] <= '0;
      end
      len_r <= LEN_W'(1);
      cnt_r <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WORD_LEN: len_r <= eff_len(cfg_data[CFG_LEN_W-1:0]);
        CFG_WORD_CNT: cnt_r <= eff_cnt(cfg_data[CFG_CNT_W-1:0]);
        default: begin
          for (int i = 0; i < WORD_REGS; i++) begin
            if (cfg_index == CFG_IDX_W'(i)) begin
              words_r[i] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  assign cfg.len = len_r;
  assign cfg.cnt = cnt_r;

  assign advance  = !(s2_v_r && hit && out_valid_r && !out_ready);
  assign in_ready = advance;
  assign in_fire  = in_valid && in_ready;

  // window chain, newest byte in cell 0
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_win
    if (i == 0) begin : g_head
      wcm_cell u_cell (
        .clk   (clk),
        .shift (in_fire),
        .clear (1'b0),
        .din   (in_text_char),
        .q     (win[i])
      );
    end else begin : g_body
      wcm_cell u_cell (
        .clk   (clk),
        .shift (in_fire),
        .clear (in_start_of_text),
        .din   (win[i-1]),
        .q     (win[i])
      );
    end
  end

  assign span_prod = len_r * cnt_r;
  assign span      = span_prod[SPAN_W-1:0];
  assign idx       = in_start_of_text ? '0 : text_position_r;
  assign past_eff  = in_start_of_text ? 1'b0 : past_end_r;

  always_comb begin
    if (in_start_of_text) begin
      bytes_seen_nxt = SPAN_W'(1);
    end else if (bytes_seen_r < SPAN_W'(WIN_DEPTH)) begin
      bytes_seen_nxt = bytes_seen_r + SPAN_W'(1);
    end else begin
      bytes_seen_nxt = bytes_seen_r;
    end
  end

  assign elig = !past_eff && (bytes_seen_nxt >= span);
  assign pos  = POS_W'(idx) + POS_W'(1) - POS_W'(span);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_position_r <= '0;
      bytes_seen_r    <= '0;
      past_end_r      <= 1'b0;
    end else if (in_fire) begin
      bytes_seen_r <= bytes_seen_nxt;
      if (past_eff) begin
        past_end_r <= 1'b1;
      end else if (idx == POS_LAST) begin
        text_position_r <= idx;
        past_end_r      <= 1'b1;
      end else begin
        text_position_r <= idx + TPOS_W'(1);
        past_end_r      <= 1'b0;
      end
    end
  end

  wcm_match u_match (
    .clk   (clk),
    .en    (advance),
    .win   (win),
    .words (words_r),
    .cfg   (cfg),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        s1_v_r <= in_fire && elig;
        s2_v_r <= s1_v_r;
      end
      if (advance && s2_v_r && hit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pos_r <= pos[MS_W-1:0];
      s2_pos_r <= s1_pos_r;
      if (s2_v_r && hit) begin
        out_pos_r <= s2_pos_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_start = out_pos_r;

  a_sot_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_start_of_text) |=> (bytes_seen_r == SPAN_W'(1)))
    else $error("start of text did not restart the window count");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_seen_r <= SPAN_W'(WIN_DEPTH))
    else $error("window byte count beyond window depth");

  a_past_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    past_end_r |-> (text_position_r == POS_LAST))
    else $error("counter stopped away from its limit");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_v_r))
    else $error("result raised without an item in the count stage");

endmodule

/* tb/word_concatenation_matcher_top_tb.sv */
`timescale 1ns / 1ps

module word_concatenation_matcher_top_tb
  import wcm_pkg::*;
();

  localparam int CYCLE_LIMIT = 20_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BYTES = 70;

  typedef struct {
    logic [7:0] ch;
    logic       sot;
  } text_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_text_char = 8'h00;
  logic                 in_start_of_text = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [MS_W-1:0]      out_match_start;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;

  word_concatenation_matcher_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_char     (in_text_char),
    .in_start_of_text (in_start_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_match_start  (out_match_start),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  text_byte_t      pending_bytes[$];
  logic [MS_W-1:0] match_starts[$];
  text_byte_t      next_byte;
  logic [MS_W-1:0] exp_start;

  int queued_count = 0;
  int accepted_count = 0;
  int matches_checked = 0;
  int config_rounds = 0;
  int errors = 0;
  int cycle_count = 0;
  int stall_requests = 0;
  int stall_served = 0;
  int hold_left = 0;
  bit no_idle = 1'b0;

  // shadow of the block: config and text state
  logic [WORD_W-1:0] word_sh [WORD_REGS];
  logic [3:0]        len_sh;
  logic [2:0]        cnt_sh;
  logic [7:0]        win [WIN_DEPTH];
  int unsigned       txt_pos;
  int unsigned       seen;
  bit                past_end;
  logic [WORD_W-1:0] cfg_words [WORD_REGS];

  function automatic int unsigned active_len();
    if (len_sh == 4'd0) return 1;
    if (len_sh > 4'(MAX_WORD_LEN)) return MAX_WORD_LEN;
    return len_sh;
  endfunction

  function automatic int unsigned active_cnt();
    if (cnt_sh == 3'd0) return 1;
    if (cnt_sh > 3'(MAX_WORDS)) return MAX_WORDS;
    return cnt_sh;
  endfunction

  function automatic void clear_text();
    int i;
    for (i = 0; i < WIN_DEPTH; i++) win[i] = 8'h00;
    txt_pos = 0;
    seen = 0;
    past_end = 1'b0;
  endfunction

  function automatic void advance_text(input logic [7:0] ch, input logic sot);
    int unsigned len, cnt, span, age;
    int i, j, k;
    logic [WORD_W-1:0] mask, chunk;
    bit used [WORD_REGS];
    bit ok, found;
    len = active_len();
    cnt = active_cnt();
    span = len * cnt;
    mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
    if (sot) clear_text();
    for (i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = ch;
    if (seen < WIN_DEPTH) seen++;
    if (!past_end) begin
      if (seen >= span) begin
        ok = 1'b1;
        for (k = 0; k < WORD_REGS; k++) used[k] = 1'b0;
        for (i = 0; i < cnt && ok; i++) begin
          chunk = '0;
          for (j = 0; j < len; j++) begin
            age = span - 1 - i * len - j;
            chunk |= WORD_W'(win[age]) << (8 * j);
          end
          found = 1'b0;
          for (k = 0; k < cnt && !found; k++) begin
            if (!used[k] && ((word_sh[k] & mask) == chunk)) begin
              used[k] = 1'b1;
              found = 1'b1;
            end
          end
          if (!found) ok = 1'b0;
        end
        if (ok) match_starts.insert(match_starts.size(), MS_W'(txt_pos + 1 - span));
      end
      if (txt_pos >= MAX_TEXT_LEN - 1) past_end = 1'b1;
      else txt_pos++;
    end
  endfunction

  function automatic bit gap_now();
    return !no_idle && ($urandom_range(99) < 17);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d bytes taken", $time, accepted_count, queued_count);
      $display("word_concatenation_matcher_top_tb failed");
      $finish;
    end
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_text(in_text_char, in_start_of_text);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && !gap_now()) begin
          next_byte = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_text_char <= next_byte.ch;
          in_start_of_text <= next_byte.sot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        matches_checked++;
        if (match_starts.size() == 0) begin
          errors++;
          $display("%0t: match_start expected none actual %0d", $time, out_match_start);
        end else begin
          exp_start = match_starts.pop_front();
          if (exp_start !== out_match_start) begin
            errors++;
            $display("%0t: match_start expected %0d actual %0d",
                     $time, exp_start, out_match_start);
          end
        end
      end
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !gap_now();
      end
    end
  end

  task automatic queue_byte(input logic [7:0] ch, input logic sot);
    text_byte_t b;
    b.ch = ch;
    b.sot = sot;
    pending_bytes.insert(pending_bytes.size(), b);
    queued_count++;
  endtask

  task automatic queue_text(input string s, input logic sot);
    int i;
    for (i = 0; i < s.len(); i++) queue_byte(s[i], sot && (i == 0));
  endtask

  task automatic wait_idle();
    while (accepted_count != queued_count || match_starts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // called at a clock edge; writes every register, words from cfg_words
  task automatic program_config(input logic [3:0] len, input logic [2:0] cnt);
    int k;
    logic [CFG_IDX_W-1:0] idx;
    logic [WORD_W-1:0] data;
    for (k = 0; k < WORD_REGS + 2; k++) begin
      data = rand_word();
      if (k < WORD_REGS) begin
        idx = CFG_IDX_W'(k);
        data = cfg_words[k];
      end else if (k == WORD_REGS) begin
        idx = CFG_WORD_LEN;
        data[3:0] = len;
      end else begin
        idx = CFG_WORD_CNT;
        data[2:0] = cnt;
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        CFG_WORD_LEN: len_sh = data[3:0];
        CFG_WORD_CNT: cnt_sh = data[2:0];
        default:      word_sh[idx] = data;
      endcase
    end
    cfg_valid <= 1'b0;
    config_rounds++;
  endtask

  task automatic queue_random_text(input int n_items);
    int unsigned len, cnt, n;
    int k, j, c, tmp, bad, first;
    int perm [WORD_REGS];
    logic sot;
    logic [7:0] b;
    len = active_len();
    cnt = active_cnt();
    first = queued_count;
    while (queued_count - first < n_items) begin
      sot = ($urandom_range(99) < 4);
      if ($urandom_range(99) < 70) begin
        for (k = 0; k < WORD_REGS; k++) perm[k] = k;
        for (k = cnt - 1; k > 0; k--) begin
          j = $urandom_range(k);
          tmp = perm[k];
          perm[k] = perm[j];
          perm[j] = tmp;
        end
        bad = ($urandom_range(99) < 15) ? int'($urandom_range(len * cnt - 1)) : -1;
        for (c = 0; c < cnt; c++) begin
          for (j = 0; j < len; j++) begin
            b = 8'(word_sh[perm[c]] >> (8 * j));
            if (c * len + j == bad) b ^= 8'(1 << $urandom_range(7));
            queue_byte(b, sot && (c == 0) && (j == 0));
          end
        end
      end else begin
        n = $urandom_range(len, 1);
        for (k = 0; k < n; k++) queue_byte(8'($urandom_range(255)), sot && (k == 0));
      end
    end
  endtask

  initial begin
    int p, k;
    logic [3:0] len;
    logic [2:0] cnt;
    for (k = 0; k < WORD_REGS; k++) word_sh[k] = '0;
    len_sh = 4'd1;
    cnt_sh = 3'd1;
    clear_text();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset config, no start flag on the first text
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    wait_idle();

    // repeated word counts twice
    for (k = 0; k < WORD_REGS; k++) cfg_words[k] = rand_word();
    cfg_words[0][23:0] = 24'h6f6f66;
    cfg_words[1][23:0] = 24'h726162;
    cfg_words[2][23:0] = 24'h6f6f66;
    program_config(4'd3, 3'd3);
    queue_text("barfoofoobar", 1'b1);
    wait_idle();

    // length 0 and count 7 clamp to 1 and 6
    for (k = 0; k < WORD_REGS; k++) cfg_words[k] = rand_word();
    cfg_words[0][7:0] = "a";
    cfg_words[1][7:0] = "b";
    cfg_words[2][7:0] = "c";
    cfg_words[3][7:0] = "a";
    cfg_words[4][7:0] = "d";
    cfg_words[5][7:0] = "e";
    program_config(4'd0, 3'd7);
    queue_text("edacbaa", 1'b1);
    wait_idle();

    // receiver held off while every byte matches
    cfg_words[0] = rand_word();
    cfg_words[0][7:0] = "A";
    program_config(4'd1, 3'd1);
    no_idle = 1'b1;
    stall_requests++;
    for (k = 0; k < 100; k++) queue_byte("A", k == 0);
    wait_idle();
    no_idle = 1'b0;

    for (p = 0; p < RANDOM_PHASES; p++) begin
      for (k = 0; k < WORD_REGS; k++) begin
        cfg_words[k] = rand_word();
        if (k > 0 && $urandom_range(99) < 30) cfg_words[k] = cfg_words[k-1];
      end
      case (p)
        0: begin len = 4'd8; cnt = 3'd6; end
        1: begin len = 4'd1; cnt = 3'd1; end
        2: begin len = 4'd15; cnt = 3'd0; end
        default: begin len = 4'($urandom_range(15)); cnt = 3'($urandom_range(7)); end
      endcase
      program_config(len, cnt);
      no_idle = (p == 3);
      queue_random_text(PHASE_BYTES);
      wait_idle();
      no_idle = 1'b0;
    end

    $display("Ran %0d text bytes over %0d register settings, %0d match starts compared,",
             accepted_count, config_rounds, matches_checked);
    $display("including clamped settings, repeated words and a long output stall.");
    if (errors == 0 && match_starts.size() == 0) begin
      $display("word_concatenation_matcher_top_tb passed");
    end else begin
      $display("%0d mismatches, %0d match starts never seen", errors, match_starts.size());
      $display("word_concatenation_matcher_top_tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/wcm_pkg.sv
rtl/wcm_cell.sv
rtl/wcm_match.sv
rtl/word_concatenation_matcher_top.sv
tb/word_concatenation_matcher_top_tb.sv
